@@ rtl/core/bgd_pkg.sv @@
package bgd_pkg;

  // Field widths
  localparam int DEV_W     = 2;
  localparam int STATUS_W  = 8;
  localparam int EVENT_W   = 3;
  localparam int TIMER_W   = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_DEVICES_DEF   = 4;
  localparam int INPUTS_PER_DEVICE = 3;

  // Input slots within one device
  localparam int IN_STICK = 0;
  localparam int IN_TRIG_A = 1;
  localparam int IN_TRIG_B = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DCLICK_TIME = 1'd1;

  localparam logic [CFG_W-1:0] HOLD_TIME_RST   = 8'd20;
  localparam logic [CFG_W-1:0] DCLICK_TIME_RST = 8'd10;

  // Input phase codes
  localparam logic [1:0] PH_OFF     = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_ON      = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Hold level codes
  localparam logic [1:0] HL_NONE    = 2'd0;
  localparam logic [1:0] HL_HOLD    = 2'd1;
  localparam logic [1:0] HL_HOLDING = 2'd2;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
  localparam logic [EVENT_W-1:0] EV_CLICK       = 3'd1;
  localparam logic [EVENT_W-1:0] EV_RELEASE     = 3'd2;
  localparam logic [EVENT_W-1:0] EV_HOLD        = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DCLICK      = 3'd4;
  localparam logic [EVENT_W-1:0] EV_DCLICK_HOLD = 3'd5;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 8'hFF;
  localparam logic [STATUS_W-1:0] STATUS_IDLE = 8'hFF;

  typedef struct packed {
    logic [DEV_W-1:0]    device;
    logic [STATUS_W-1:0] status;
  } in_t;

  typedef struct packed {
    logic [EVENT_W-1:0] stick_event;
    logic [EVENT_W-1:0] button_a_event;
    logic [EVENT_W-1:0] button_b_event;
  } out_t;

  // Per-input tracking state
  typedef struct packed {
    logic [1:0]         ph;
    logic [1:0]         hl;
    logic               dbl;
    logic [TIMER_W-1:0] tm;
  } inp_t;

  // One memory entry per device
  typedef struct packed {
    logic [STATUS_W-1:0]                 prev;
    inp_t [INPUTS_PER_DEVICE-1:0]        inp;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  localparam inp_t INP_RST = '{ph: PH_OFF, hl: HL_NONE, dbl: 1'b0, tm: TIMER_MAX};
  localparam ent_t ENT_RST = '{prev: STATUS_IDLE, inp: {INPUTS_PER_DEVICE{INP_RST}}};

endpackage

@@ rtl/core/button_gesture_detector.sv @@
// Button gesture detector: takes one poll transaction per cycle unless the output stalls,
// each carrying a device number and its active-low status byte, and returns one result
// per transaction with click, release, hold, double-click and double-click-hold codes for
// the stick and triggers A and B. An accepted transaction is registered into the update
// stage and its result into the output register; the rate is set by the read-modify-write
// of the per-device state RAM in the update stage (one entry per device, read on accept
// and written back from the update stage, with the previous write forwarded when the same
// device follows directly). Entries never written read as the reset state through per-device
// valid flags, so no clearing pass follows reset. Devices at or beyond NUM_DEVICES change
// nothing and report no events. The user must write hold_time and double_click_time through
// the cfg port while the block is idle; the block itself does not enforce this.
module button_gesture_detector
  import bgd_pkg::*;
#(
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int XW = AW + DEV_W;

  logic [CFG_W-1:0] hold_time_r;
  logic [CFG_W-1:0] dclick_time_r;

  logic             s1_valid_r;
  logic             s1_inr_r;
  logic [AW-1:0]    s1_addr_r;
  logic [STATUS_W-1:0] s1_status_r;

  logic             out_valid_r;
  out_t             out_data_r;

  logic [NUM_DEVICES-1:0] vld_r;
  logic             fwd_hit_r;
  logic [AW-1:0]    fwd_addr_r;
  ent_t             fwd_data_r;

  logic             in_accept;
  logic             s1_fire;
  logic [XW-1:0]    in_dev_ext;
  logic [AW-1:0]    in_addr;
  logic             in_inr;
  logic [AW-1:0]    rd_addr;
  logic [ENT_W-1:0] ram_rdata;
  logic             ram_we;
  ent_t             cur_ent;
  ent_t             new_ent;
  out_t             s1_result;

  // Saturating timer step, phase/hold transition, then edge override
  function automatic inp_t step_input(inp_t st, logic c, logic p,
                                      logic [CFG_W-1:0] ht, logic [CFG_W-1:0] dct);
    inp_t r;
    r = st;
    if (r.tm != TIMER_MAX) begin
      r.tm = r.tm + 1'b1;
    end
    if (r.ph == PH_PRESS) begin
      r.ph = PH_ON;
    end else if (r.ph == PH_RELEASE) begin
      r.ph = PH_OFF;
      r.hl = HL_NONE;
    end else if (r.hl == HL_NONE && r.ph == PH_ON && r.tm > ht) begin
      r.hl = HL_HOLD;
    end else if (r.hl == HL_HOLD) begin
      r.hl = HL_HOLDING;
    end else if (r.ph == PH_OFF && r.tm > dct) begin
      r.dbl = 1'b0;
    end
    if (c && !p) begin
      r.ph = PH_PRESS;
      if (r.tm <= dct) begin
        r.dbl = 1'b1;
      end
      r.tm = '0;
    end else if (!c && p) begin
      r.ph  = PH_RELEASE;
      r.hl  = HL_NONE;
      r.dbl = 1'b0;
      r.tm  = '0;
    end
    return r;
  endfunction

  function automatic logic [EVENT_W-1:0] event_of(inp_t st);
    logic [EVENT_W-1:0] ev;
    ev = EV_NONE;
    if (st.ph == PH_RELEASE) begin
      ev = EV_RELEASE;
    end else if (st.ph == PH_PRESS && st.hl == HL_NONE) begin
      ev = st.dbl ? EV_DCLICK : EV_CLICK;
    end else if (st.ph == PH_ON && st.hl == HL_HOLD) begin
      ev = st.dbl ? EV_DCLICK_HOLD : EV_HOLD;
    end
    return ev;
  endfunction

  function automatic logic is_on(logic [STATUS_W-1:0] st, int which);
    logic on;
    case (which)
      IN_STICK:  on = (st[3:0] != 4'hF);
      IN_TRIG_A: on = !st[4];
      IN_TRIG_B: on = !st[5];
      default:   on = 1'b0;
    endcase
    return on;
  endfunction

  // Handshake and address decode
  assign s1_fire    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_fire;
  assign in_accept  = in_valid && in_ready;
  assign in_dev_ext = {{AW{1'b0}}, in_data.device};
  assign in_addr    = in_dev_ext[AW-1:0];
  assign in_inr     = (in_dev_ext < XW'(NUM_DEVICES));

  // Read ahead for the incoming transaction, else re-read the held one
  assign rd_addr = in_accept ? in_addr : s1_addr_r;
  assign ram_we  = s1_fire && s1_inr_r;

  bgd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_DEVICES),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (new_ent),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Pick forwarded, stored or reset entry, then update every input
  always_comb begin
    if (fwd_hit_r && fwd_addr_r == s1_addr_r) begin
      cur_ent = fwd_data_r;
    end else if (vld_r[s1_addr_r]) begin
      cur_ent = ent_t'(ram_rdata);
    end else begin
      cur_ent = ENT_RST;
    end
    new_ent.prev = s1_status_r;
    for (int i = 0; i < INPUTS_PER_DEVICE; i++) begin
      new_ent.inp[i] = step_input(cur_ent.inp[i], is_on(s1_status_r, i),
                                  is_on(cur_ent.prev, i), hold_time_r, dclick_time_r);
    end
    if (s1_inr_r) begin
      s1_result.stick_event    = event_of(new_ent.inp[IN_STICK]);
      s1_result.button_a_event = event_of(new_ent.inp[IN_TRIG_A]);
      s1_result.button_b_event = event_of(new_ent.inp[IN_TRIG_B]);
    end else begin
      s1_result = '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r   <= HOLD_TIME_RST;
      dclick_time_r <= DCLICK_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_TIME:   hold_time_r   <= cfg_wdata;
        CFG_DCLICK_TIME: dclick_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Update stage, output register, valid flags and forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      fwd_hit_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      fwd_hit_r <= ram_we;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r   <= in_addr;
      s1_inr_r    <= in_inr;
      s1_status_r <= in_data.status;
    end
    if (s1_fire) begin
      out_data_r <= s1_result;
    end
    if (ram_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_ent;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Hold off new transactions while the update stage is blocked
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while update stage blocked");

  // A written entry is marked valid on the next cycle
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> vld_r[$past(s1_addr_r)])
    else $error("written entry not marked valid");

  // An out-of-range device reports no events
  a_oor_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_inr_r) |=> (out_data_r == '0))
    else $error("out-of-range device produced an event");

  // Event codes stay within the defined set
  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.stick_event <= EV_DCLICK_HOLD &&
                     out_data_r.button_a_event <= EV_DCLICK_HOLD &&
                     out_data_r.button_b_event <= EV_DCLICK_HOLD))
    else $error("undefined event code on output");

endmodule

@@ rtl/core/bgd_ram.sv @@
module bgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ dv/button_gesture_detector_tb.sv @@
module button_gesture_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int IDLE_PCT = 12;

  // One directed poll: expected events are used only where typed is set
  typedef struct packed {
    logic [DEV_W-1:0]    device;
    logic [STATUS_W-1:0] status;
    logic                typed;
    out_t                ev;
  } poll_row_t;

  localparam int NUM_ROWS = 24;
  localparam poll_row_t POLL_ROWS [NUM_ROWS] = '{
    // reset timing: single press, release, quick re-press
    '{2'd0, 8'hFF, 1'b1, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd0, 8'hEF, 1'b1, '{EV_NONE,  EV_CLICK,   EV_NONE}},
    '{2'd0, 8'hEF, 1'b1, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd0, 8'hFF, 1'b1, '{EV_NONE,  EV_RELEASE, EV_NONE}},
    '{2'd0, 8'hEF, 1'b1, '{EV_NONE,  EV_DCLICK,  EV_NONE}},
    '{2'd1, 8'h00, 1'b1, '{EV_CLICK, EV_CLICK,   EV_CLICK}},
    '{2'd1, 8'hC0, 1'b1, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd2, 8'hFE, 1'b1, '{EV_CLICK, EV_NONE,    EV_NONE}},
    '{2'd2, 8'hF7, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd3, 8'hDF, 1'b1, '{EV_NONE,  EV_NONE,    EV_CLICK}},
    '{2'd0, 8'h3F, 1'b1, '{EV_NONE,  EV_RELEASE, EV_NONE}},
    // zero timing: immediate hold, no double
    '{2'd3, 8'hDF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd3, 8'hDF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd3, 8'hDF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd3, 8'hFF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd3, 8'hDF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd2, 8'hFF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd2, 8'hFB, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd1, 8'hFF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd1, 8'h00, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    // maximum timing: saturated timer, wide double window
    '{2'd0, 8'hFF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd0, 8'hEF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd0, 8'hFF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}},
    '{2'd0, 8'hEF, 1'b0, '{EV_NONE,  EV_NONE,    EV_NONE}}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HOLD_TIME;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Typed expectation travels beside the offered transaction
  logic row_typed = 1'b0;
  out_t row_events = '0;

  logic quiet_mode = 1'b0;
  logic holdoff_req = 1'b0;

  int   mismatch_count = 0;
  int   cycle_count = 0;
  out_t pending_events [$];

  // Predictor copy of the block state and timing registers
  logic [CFG_W-1:0]    hold_ticks = HOLD_TIME_RST;
  logic [CFG_W-1:0]    dclick_ticks = DCLICK_TIME_RST;
  logic [STATUS_W-1:0] last_status [NUM_DEVICES_DEF];
  logic [1:0]          phase_q [NUM_DEVICES_DEF][INPUTS_PER_DEVICE];
  logic [1:0]          hold_q [NUM_DEVICES_DEF][INPUTS_PER_DEVICE];
  logic                dbl_q [NUM_DEVICES_DEF][INPUTS_PER_DEVICE];
  logic [TIMER_W-1:0]  timer_q [NUM_DEVICES_DEF][INPUTS_PER_DEVICE];

  // Held button pattern per device for well-formed gestures
  logic [5:0] device_buttons [NUM_DEVICES_DEF];

  button_gesture_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int d = 0; d < NUM_DEVICES_DEF; d++) begin
      last_status[d] = STATUS_IDLE;
      device_buttons[d] = 6'h3F;
      for (int k = 0; k < INPUTS_PER_DEVICE; k++) begin
        phase_q[d][k] = PH_OFF;
        hold_q[d][k] = HL_NONE;
        dbl_q[d][k] = 1'b0;
        timer_q[d][k] = TIMER_MAX;
      end
    end
  end

  function automatic logic input_pressed(logic [STATUS_W-1:0] st, int slot);
    if (slot == IN_STICK) return st[3:0] != 4'hF;
    if (slot == IN_TRIG_A) return !st[4];
    return !st[5];
  endfunction

  // Advance the gesture state of one device and return its three event codes
  function automatic out_t predict_events(in_t item);
    logic [STATUS_W-1:0] prev_st;
    logic [1:0]          ph;
    logic [1:0]          hl;
    logic                dbl;
    logic [TIMER_W-1:0]  tm;
    logic                now_on;
    logic                was_on;
    logic [EVENT_W-1:0]  codes [INPUTS_PER_DEVICE];
    if (int'(item.device) >= NUM_DEVICES_DEF) return '0;
    prev_st = last_status[item.device];
    last_status[item.device] = item.status;
    for (int k = 0; k < INPUTS_PER_DEVICE; k++) begin
      ph = phase_q[item.device][k];
      hl = hold_q[item.device][k];
      dbl = dbl_q[item.device][k];
      tm = timer_q[item.device][k];
      now_on = input_pressed(item.status, k);
      was_on = input_pressed(prev_st, k);
      if (tm != TIMER_MAX) tm = tm + 1'b1;
      // phase and hold step
      if (ph == PH_PRESS) begin
        ph = PH_ON;
      end else if (ph == PH_RELEASE) begin
        ph = PH_OFF;
        hl = HL_NONE;
      end else if (hl == HL_NONE && ph == PH_ON && tm > hold_ticks) begin
        hl = HL_HOLD;
      end else if (hl == HL_HOLD) begin
        hl = HL_HOLDING;
      end else if (ph == PH_OFF && tm > dclick_ticks) begin
        dbl = 1'b0;
      end
      // edge overrides the phase
      if (now_on && !was_on) begin
        ph = PH_PRESS;
        if (tm <= dclick_ticks) dbl = 1'b1;
        tm = '0;
      end else if (!now_on && was_on) begin
        ph = PH_RELEASE;
        hl = HL_NONE;
        dbl = 1'b0;
        tm = '0;
      end
      phase_q[item.device][k] = ph;
      hold_q[item.device][k] = hl;
      dbl_q[item.device][k] = dbl;
      timer_q[item.device][k] = tm;
      if (ph == PH_RELEASE) codes[k] = EV_RELEASE;
      else if (ph == PH_PRESS && hl == HL_NONE) codes[k] = dbl ? EV_DCLICK : EV_CLICK;
      else if (ph == PH_ON && hl == HL_HOLD) codes[k] = dbl ? EV_DCLICK_HOLD : EV_HOLD;
      else codes[k] = EV_NONE;
    end
    return '{codes[IN_STICK], codes[IN_TRIG_A], codes[IN_TRIG_B]};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Check finished transactions first, then predict the newly accepted one
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result, stick", int'(out_data.stick_event), 0);
      end else begin
        want = pending_events.pop_front();
        if (out_data.stick_event !== want.stick_event)
          report_mismatch("stick_event", int'(out_data.stick_event),
                          int'(want.stick_event));
        if (out_data.button_a_event !== want.button_a_event)
          report_mismatch("button_a_event", int'(out_data.button_a_event),
                          int'(want.button_a_event));
        if (out_data.button_b_event !== want.button_b_event)
          report_mismatch("button_b_event", int'(out_data.button_b_event),
                          int'(want.button_b_event));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      want = predict_events(in_data);
      if (row_typed) want = row_events;
      pending_events.push_back(want);
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      out_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one poll transaction and hold it until accepted
  task automatic send_poll(input in_t item, input logic typed, input out_t ev);
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    row_typed <= typed;
    row_events <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait out all pending results and the pipeline
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] hold_v, input logic [CFG_W-1:0] dclick_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HOLD_TIME;
    cfg_wdata <= hold_v;
    @(negedge clk);
    cfg_index <= CFG_DCLICK_TIME;
    cfg_wdata <= dclick_v;
    @(negedge clk);
    cfg_we <= 1'b0;
    hold_ticks = hold_v;
    dclick_ticks = dclick_v;
  endtask

  task automatic run_rows(input int first, input int last);
    in_t item;
    for (int r = first; r <= last; r++) begin
      item.device = POLL_ROWS[r].device;
      item.status = POLL_ROWS[r].status;
      send_poll(item, POLL_ROWS[r].typed, POLL_ROWS[r].ev);
    end
  endtask

  // Mostly held patterns with occasional flips, plus a little noise
  task automatic run_gestures(input int count);
    in_t item;
    int  dev;
    int  pick;
    int  flip;
    for (int n = 0; n < count; n++) begin
      dev = $urandom_range(NUM_DEVICES_DEF - 1);
      pick = $urandom_range(99);
      if (pick < 4) begin
        item.status = 8'($urandom_range(255));
      end else begin
        if (pick < 22) begin
          flip = $urandom_range(5);
          device_buttons[dev][flip] = ~device_buttons[dev][flip];
        end else if (pick < 24) begin
          device_buttons[dev] = 6'h3F;
        end
        item.status = {2'($urandom_range(3)), device_buttons[dev]};
      end
      item.device = dev[DEV_W-1:0];
      send_poll(item, 1'b0, '0);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed polls across timing extremes
    run_rows(0, 10);
    drain_results();
    set_timing(8'd0, 8'd0);
    run_rows(11, 19);
    drain_results();
    set_timing(8'd255, 8'd255);
    run_rows(20, NUM_ROWS - 1);
    drain_results();

    // random gestures under varied timing
    set_timing(8'($urandom_range(1, 30)), 8'($urandom_range(0, 15)));
    run_gestures(400);
    drain_results();

    set_timing(8'd255, 8'd0);
    holdoff_req <= 1'b1;
    run_gestures(390);
    drain_results();

    set_timing(8'd0, 8'd255);
    quiet_mode <= 1'b1;
    run_gestures(390);
    drain_results();
    quiet_mode <= 1'b0;

    set_timing(HOLD_TIME_RST, DCLICK_TIME_RST);
    run_gestures(380);
    drain_results();

    set_timing(8'($urandom_range(255)), 8'($urandom_range(255)));
    run_gestures(370);
    drain_results();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
